>>> rtl/modulation_matrix_sum_defines.svh
// ----------------------------------------------------------------------------
// Modulation matrix sum assertion macros
// Concurrent assertion helpers used by the matrix sum engine. They expand to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MODULATION_MATRIX_SUM_DEFINES_SVH
`define MODULATION_MATRIX_SUM_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define MMS_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error(msg);

// Next-cycle implication.
`define MMS_ASSERT_NXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error(msg);

`else

`define MMS_ASSERT_IMP(label, clk, rst, lhs, rhs, msg)
`define MMS_ASSERT_NXT(label, clk, rst, lhs, rhs, msg)

`endif

`endif

>>> rtl/mms_pkg.sv
// ----------------------------------------------------------------------------
// Modulation matrix sum package
// Request codes, the queued command format and the engine state type.
// ----------------------------------------------------------------------------
package mms_pkg;

   typedef enum logic [1:0] {
      REQ_WRITE_SLOT   = 2'd0,
      REQ_WRITE_SOURCE = 2'd1,
      REQ_EVAL         = 2'd2,
      REQ_CLEAR        = 2'd3
   } req_kind_type;

   localparam int CMD_QUEUE_DEPTH = 4;

   // One classified request as it waits between the front end and the engine.
   // The value word (depth or source value) travels beside it in the queue.
   typedef struct packed {
      req_kind_type kind;
      logic [3:0]   index;   // slot index or source index
      logic [3:0]   source;  // source routed by a slot
      logic [4:0]   target;  // slot target or target to evaluate
      logic         active;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } eng_state_type;

endpackage

>>> rtl/mms_front.sv
// ----------------------------------------------------------------------------
// Modulation matrix sum front end
// Unpacks a request, range-checks its indexes and hands it to the command
// queue. Writes to slots or sources that do not exist are dropped here.
// ----------------------------------------------------------------------------
module mms_front #(
   parameter int  VALUE_BITS   = 16,
   parameter int  SLOT_COUNT   = 16,
   parameter int  SOURCE_COUNT = 11,
   localparam int REQ_BITS     = 23 + 2 * VALUE_BITS,
   localparam int REQ_TDATA_W  = ((REQ_BITS + 7) / 8) * 8
) (
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [1:0]             req_tuser,
   input  logic                   queue_full,
   output logic                   queue_push,
   output mms_pkg::cmd_type       push_cmd,
   output logic [VALUE_BITS-1:0]  push_value
);

   localparam int OFF_DEPTH   = 13;
   localparam int OFF_ACTIVE  = 13 + VALUE_BITS;
   localparam int OFF_SRC_IDX = 14 + VALUE_BITS;
   localparam int OFF_SRC_VAL = 18 + VALUE_BITS;
   localparam int OFF_EVAL    = 18 + 2 * VALUE_BITS;

   mms_pkg::req_kind_type  kind;
   logic [3:0]             slot_index;
   logic [3:0]             slot_source;
   logic [4:0]             slot_target;
   logic [VALUE_BITS-1:0]  slot_depth;
   logic                   slot_active;
   logic [3:0]             source_index;
   logic [VALUE_BITS-1:0]  source_value;
   logic [4:0]             eval_target;
   logic                   keep;

   assign kind         = mms_pkg::req_kind_type'(req_tuser);
   assign slot_index   = req_tdata[3:0];
   assign slot_source  = req_tdata[7:4];
   assign slot_target  = req_tdata[12:8];
   assign slot_depth   = req_tdata[OFF_DEPTH +: VALUE_BITS];
   assign slot_active  = req_tdata[OFF_ACTIVE];
   assign source_index = req_tdata[OFF_SRC_IDX +: 4];
   assign source_value = req_tdata[OFF_SRC_VAL +: VALUE_BITS];
   assign eval_target  = req_tdata[OFF_EVAL +: 5];

   always_comb begin
      case (kind)
         mms_pkg::REQ_WRITE_SLOT: begin
            keep = 7'(slot_index) < 7'(SLOT_COUNT);
         end
         mms_pkg::REQ_WRITE_SOURCE: begin
            keep = 5'(source_index) < 5'(SOURCE_COUNT);
         end
         default: begin
            keep = 1'b1;
         end
      endcase
   end

   always_comb begin
      push_cmd.kind   = kind;
      push_cmd.index  = (kind == mms_pkg::REQ_WRITE_SOURCE) ? source_index : slot_index;
      push_cmd.source = slot_source;
      push_cmd.target = (kind == mms_pkg::REQ_EVAL) ? eval_target : slot_target;
      push_cmd.active = slot_active;
      push_value      = (kind == mms_pkg::REQ_WRITE_SOURCE) ? source_value : slot_depth;
   end

   assign req_tready = !queue_full;
   assign queue_push = req_tvalid && !queue_full && keep;

endmodule

>>> rtl/mms_cmd_fifo.sv
// ----------------------------------------------------------------------------
// Modulation matrix sum command queue
// Small first-in first-out buffer between the front end and the engine.
// ----------------------------------------------------------------------------
module mms_cmd_fifo #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = count_ff == CW'(DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/mms_engine.sv
// ----------------------------------------------------------------------------
// Modulation matrix sum engine
// Holds the slot and source tables, applies writes and clears, and runs the
// multiply-accumulate sweep over the slots for an evaluate.
// ----------------------------------------------------------------------------
`include "modulation_matrix_sum_defines.svh"

module mms_engine #(
   parameter int VALUE_BITS   = 16,
   parameter int SLOT_COUNT   = 16,
   parameter int SOURCE_COUNT = 11
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_empty,
   input  mms_pkg::cmd_type      cmd_head,
   input  logic [VALUE_BITS-1:0] cmd_value,
   output logic                  cmd_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [VALUE_BITS-1:0] rsp_data
);

   localparam int SLOT_AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int SRC_AW  = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1;
   localparam int PROD_W  = 2 * VALUE_BITS;
   localparam int ACC_W   = PROD_W + $clog2(SLOT_COUNT) + 1;
   localparam logic signed [ACC_W-1:0] ROUND_ACC = ACC_W'(1 << (VALUE_BITS - 2));
   localparam logic signed [ACC_W-1:0] VMAX_ACC  = ACC_W'((1 << (VALUE_BITS - 1)) - 1);
   localparam logic signed [ACC_W-1:0] VMIN_ACC  = ~VMAX_ACC;

   // Slot memory; the active flags live in flip-flops so that reset and
   // clear-all can drop every route at once.
   logic [3:0]             slot_src_mem   [SLOT_COUNT];
   logic [4:0]             slot_tgt_mem   [SLOT_COUNT];
   logic [VALUE_BITS-1:0]  slot_depth_mem [SLOT_COUNT];

   logic                   slot_on_ff [SLOT_COUNT];
   logic                   slot_on_in [SLOT_COUNT];
   logic signed [VALUE_BITS-1:0] src_tbl_ff [SOURCE_COUNT];
   logic signed [VALUE_BITS-1:0] src_tbl_in [SOURCE_COUNT];

   mms_pkg::eng_state_type state_ff, state_in;
   logic [SLOT_AW-1:0]     cnt_ff, cnt_in;
   logic                   s1_valid_ff, s1_valid_in;
   logic                   s2_valid_ff, s2_valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0]  rsp_data_ff, rsp_data_in;
   logic [4:0]             tgt_ff, tgt_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   logic [3:0]             rd_src_ff;
   logic [4:0]             rd_tgt_ff;
   logic signed [VALUE_BITS-1:0] rd_depth_ff;
   logic                   rd_on_ff;

   logic                   slot_we;
   logic [SLOT_AW-1:0]     slot_wa;
   logic [SRC_AW-1:0]      src_wa;
   logic signed [VALUE_BITS-1:0] src_sel;
   logic signed [PROD_W-1:0] mult;
   logic                   match;
   logic signed [ACC_W-1:0] rounded;
   logic [VALUE_BITS-1:0]  clamped;

   assign slot_wa = SLOT_AW'(cmd_head.index);
   assign src_wa  = SRC_AW'(cmd_head.index);

   // Read, multiply and accumulate stages of the slot sweep.
   always_comb begin
      if (5'(rd_src_ff) < 5'(SOURCE_COUNT)) begin
         src_sel = src_tbl_ff[SRC_AW'(rd_src_ff)];
      end else begin
         src_sel = '0;
      end
   end

   assign match       = rd_on_ff && (rd_tgt_ff == tgt_ff);
   assign mult        = src_sel * rd_depth_ff;
   assign prod_in     = match ? mult : '0;
   assign s1_valid_in = state_ff == mms_pkg::ST_RUN;
   assign s2_valid_in = s1_valid_ff;

   // Round to nearest with ties upward, then saturate.
   assign rounded = (acc_ff + ROUND_ACC) >>> (VALUE_BITS - 1);

   always_comb begin
      if (rounded > VMAX_ACC) begin
         clamped = VMAX_ACC[VALUE_BITS-1:0];
      end else if (rounded < VMIN_ACC) begin
         clamped = VMIN_ACC[VALUE_BITS-1:0];
      end else begin
         clamped = rounded[VALUE_BITS-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      tgt_in       = tgt_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      slot_on_in   = slot_on_ff;
      src_tbl_in   = src_tbl_ff;
      cmd_pop      = 1'b0;
      slot_we      = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (s2_valid_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end

      case (state_ff)
         mms_pkg::ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               case (cmd_head.kind)
                  mms_pkg::REQ_WRITE_SLOT: begin
                     slot_we             = 1'b1;
                     slot_on_in[slot_wa] = cmd_head.active;
                  end
                  mms_pkg::REQ_WRITE_SOURCE: begin
                     src_tbl_in[src_wa] = cmd_value;
                  end
                  mms_pkg::REQ_EVAL: begin
                     tgt_in   = cmd_head.target;
                     acc_in   = '0;
                     cnt_in   = '0;
                     state_in = mms_pkg::ST_RUN;
                  end
                  mms_pkg::REQ_CLEAR: begin
                     slot_on_in = '{default: 1'b0};
                     src_tbl_in = '{default: '0};
                  end
                  default: begin
                  end
               endcase
            end
         end
         mms_pkg::ST_RUN: begin
            if (cnt_ff == SLOT_AW'(SLOT_COUNT - 1)) begin
               state_in = mms_pkg::ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         mms_pkg::ST_DRAIN: begin
            if (!s1_valid_ff && !s2_valid_ff) begin
               state_in = mms_pkg::ST_FINISH;
            end
         end
         mms_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = clamped;
               state_in     = mms_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mms_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mms_pkg::ST_IDLE;
         cnt_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         slot_on_ff   <= '{default: 1'b0};
         src_tbl_ff   <= '{default: '0};
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         slot_on_ff   <= slot_on_in;
         src_tbl_ff   <= src_tbl_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff      <= tgt_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_src_mem[slot_wa]   <= cmd_head.source;
         slot_tgt_mem[slot_wa]   <= cmd_head.target;
         slot_depth_mem[slot_wa] <= cmd_value;
      end
      rd_src_ff   <= slot_src_mem[cnt_ff];
      rd_tgt_ff   <= slot_tgt_mem[cnt_ff];
      rd_depth_ff <= slot_depth_mem[cnt_ff];
      rd_on_ff    <= slot_on_ff[cnt_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   `MMS_ASSERT_NXT(a_eval_start, clock, reset,
      cmd_pop && cmd_head.kind == mms_pkg::REQ_EVAL,
      acc_ff == '0 && cnt_ff == '0 && state_ff == mms_pkg::ST_RUN,
      "evaluate did not start with a cleared accumulator")
   `MMS_ASSERT_IMP(a_drained, clock, reset, state_ff == mms_pkg::ST_FINISH,
      !s1_valid_ff && !s2_valid_ff, "sum finished with products still in flight")
   `MMS_ASSERT_NXT(a_rsp_origin, clock, reset,
      !rsp_valid_ff && state_ff != mms_pkg::ST_FINISH, !rsp_valid_ff,
      "response raised outside the finish step")
   `MMS_ASSERT_IMP(a_read_origin, clock, reset, s1_valid_ff,
      $past(state_ff == mms_pkg::ST_RUN), "slot read valid without a sweep")

endmodule

>>> rtl/modulation_matrix_sum.sv
// ----------------------------------------------------------------------------
// Modulation matrix sum
// Holds SLOT_COUNT routing slots and SOURCE_COUNT source values and sums
// source times depth over the active slots that route to a requested target,
// giving a rounded and saturated signed Q1.15 result. The front end takes one
// request per cycle while the four-entry command queue has room. The engine
// retires a slot write, source write or clear-all as it pops it from the queue;
// an evaluate holds the engine while it takes the command, while the single
// multiply-accumulate unit steps through the slot memory, while its read,
// multiply and accumulate stages drain, and during a round-and-clamp step,
// which stretches for as long as an earlier result still waits in the
// response register. Only evaluate requests produce a response; the response
// register lets the engine carry on with later requests while a result waits.
// ----------------------------------------------------------------------------
module modulation_matrix_sum #(
   parameter int  SLOT_COUNT   = 16,
   parameter int  SOURCE_COUNT = 11,
   parameter int  VALUE_BITS   = 16,
   localparam int REQ_BITS     = 23 + 2 * VALUE_BITS,
   localparam int REQ_TDATA_W  = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_TDATA_W  = ((VALUE_BITS + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // From bit 0 up: slot_index(4), slot_source(4), slot_target(5),
   // slot_depth(VALUE_BITS), slot_active(1), source_index(4),
   // source_value(VALUE_BITS), eval_target(5), zero fill.
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // req_type(2).
   input  logic [1:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // From bit 0 up: mod_value(VALUE_BITS), zero fill.
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int CMD_W   = $bits(mms_pkg::cmd_type);
   localparam int QUEUE_W = CMD_W + VALUE_BITS;

   logic                  queue_full;
   logic                  queue_push;
   mms_pkg::cmd_type      push_cmd;
   logic [VALUE_BITS-1:0] push_value;
   logic [QUEUE_W-1:0]    push_data;
   logic [QUEUE_W-1:0]    pop_data;
   logic                  queue_empty;
   logic                  queue_pop;
   mms_pkg::cmd_type      head_cmd;
   logic [VALUE_BITS-1:0] head_value;
   logic [VALUE_BITS-1:0] rsp_data;

   mms_front #(
      .VALUE_BITS   (VALUE_BITS),
      .SLOT_COUNT   (SLOT_COUNT),
      .SOURCE_COUNT (SOURCE_COUNT)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .queue_push (queue_push),
      .push_cmd   (push_cmd),
      .push_value (push_value)
   );

   assign push_data = {push_cmd, push_value};

   mms_cmd_fifo #(
      .WIDTH (QUEUE_W),
      .DEPTH (mms_pkg::CMD_QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   assign head_cmd   = pop_data[QUEUE_W-1:VALUE_BITS];
   assign head_value = pop_data[VALUE_BITS-1:0];

   mms_engine #(
      .VALUE_BITS   (VALUE_BITS),
      .SLOT_COUNT   (SLOT_COUNT),
      .SOURCE_COUNT (SOURCE_COUNT)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd_empty  (queue_empty),
      .cmd_head   (head_cmd),
      .cmd_value  (head_value),
      .cmd_pop    (queue_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data)
   );

   assign rsp_tdata = RSP_TDATA_W'(rsp_data);

endmodule

>>> verif/modulation_matrix_sum_checker.sv
// ----------------------------------------------------------------------------
// Modulation matrix sum checker
// Watches the request and response streams of the matrix summer, keeps its
// own copy of the slot and source tables, predicts the clamped Q1.15 sum of
// every evaluate request and compares each response with the oldest one.
// ----------------------------------------------------------------------------
module modulation_matrix_sum_checker
   import mms_pkg::*;
#(
   parameter int SLOT_COUNT   = 16,
   parameter int SOURCE_COUNT = 11
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // From bit 0 up: slot_index(4), slot_source(4), slot_target(5),
   // slot_depth(16), slot_active(1), source_index(4), source_value(16),
   // eval_target(5), zero fill(1).
   input  logic [55:0] req_tdata,
   // req_type(2).
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // From bit 0 up: mod_value(16).
   input  logic [15:0] rsp_tdata,
   output int          error_count,
   output int          pending_count,
   output int          checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;
   localparam longint SUM_MAX  = 32767;
   localparam longint SUM_MIN  = -32768;

   typedef struct packed {
      logic               fill;
      logic [4:0]         eval_target;
      logic signed [15:0] source_value;
      logic [3:0]         source_index;
      logic               slot_active;
      logic signed [15:0] slot_depth;
      logic [4:0]         slot_target;
      logic [3:0]         slot_source;
      logic [3:0]         slot_index;
   } request_fields_type;

   logic [3:0]         route_source [SLOT_COUNT];
   logic [4:0]         route_target [SLOT_COUNT];
   logic signed [15:0] route_depth  [SLOT_COUNT];
   logic               route_on     [SLOT_COUNT];
   logic signed [15:0] source_level [SOURCE_COUNT];

   logic [15:0] expected_mod_values [$];
   int          report_count;

   function automatic logic [15:0] predict_mod_value(input logic [4:0] target);
      longint acc;
      longint rounded;
      longint level;
      acc = 0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (route_on[i] && route_target[i] == target) begin
            // A slot routed past the last source reads zero.
            level = (route_source[i] < SOURCE_COUNT) ?
                    longint'(source_level[route_source[i]]) : 0;
            acc += level * longint'(route_depth[i]);
         end
      end
      // Round to nearest with ties toward plus infinity, then saturate.
      rounded = (acc + 16384) >>> 15;
      if (rounded > SUM_MAX) rounded = SUM_MAX;
      if (rounded < SUM_MIN) rounded = SUM_MIN;
      return rounded[15:0];
   endfunction

   task automatic clear_tables();
      for (int i = 0; i < SLOT_COUNT; i++) begin
         route_source[i] = '0;
         route_target[i] = '0;
         route_depth[i]  = '0;
         route_on[i]     = 1'b0;
      end
      for (int i = 0; i < SOURCE_COUNT; i++) begin
         source_level[i] = '0;
      end
   endtask

   always @(posedge clock) begin
      request_fields_type fields;
      logic [15:0]        expected;
      if (reset) begin
         clear_tables();
         expected_mod_values.delete();
         error_count   <= 0;
         pending_count <= 0;
         checked_count <= 0;
         report_count   = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            fields = request_fields_type'(req_tdata);
            case (req_kind_type'(req_tuser))
               REQ_WRITE_SLOT: begin
                  if (fields.slot_index < SLOT_COUNT) begin
                     route_source[fields.slot_index] = fields.slot_source;
                     route_target[fields.slot_index] = fields.slot_target;
                     route_depth[fields.slot_index]  = fields.slot_depth;
                     route_on[fields.slot_index]     = fields.slot_active;
                  end
               end
               REQ_WRITE_SOURCE: begin
                  if (fields.source_index < SOURCE_COUNT) begin
                     source_level[fields.source_index] = fields.source_value;
                  end
               end
               REQ_EVAL: begin
                  expected_mod_values.push_back(predict_mod_value(fields.eval_target));
               end
               default: begin
                  clear_tables();
               end
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_mod_values.size() == 0) begin
               error_count <= error_count + 1;
               if (report_count < REPORT_LIMIT) begin
                  $display("%0t: unexpected response, mod_value %0d", $realtime,
                           $signed(rsp_tdata));
               end
               report_count++;
            end else begin
               expected = expected_mod_values.pop_front();
               checked_count <= checked_count + 1;
               if (rsp_tdata !== expected) begin
                  error_count <= error_count + 1;
                  if (report_count < REPORT_LIMIT) begin
                     $display("%0t: mod_value mismatch, expected %0d, actual %0d",
                              $realtime, $signed(expected), $signed(rsp_tdata));
                  end
                  report_count++;
               end
            end
         end
         pending_count <= expected_mod_values.size();
      end
   end

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// Modulation matrix sum testbench
// Drives slot writes, source writes, evaluates and clears into the matrix
// summer with random gaps on the request side and random stalls on the
// response side; a separate checker predicts and compares every response.
// ----------------------------------------------------------------------------
module testbench;
   import mms_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_REQUESTS = 850;
   localparam int DRAIN_CYCLES    = 200;
   localparam int CYCLE_LIMIT     = 400000;

   typedef struct packed {
      logic               fill;
      logic [4:0]         eval_target;
      logic signed [15:0] source_value;
      logic [3:0]         source_index;
      logic               slot_active;
      logic signed [15:0] slot_depth;
      logic [4:0]         slot_target;
      logic [3:0]         slot_source;
      logic [3:0]         slot_index;
   } request_fields_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // From bit 0 up: slot_index(4), slot_source(4), slot_target(5),
   // slot_depth(16), slot_active(1), source_index(4), source_value(16),
   // eval_target(5), zero fill(1).
   logic [55:0] req_tdata  = '0;
   // req_type(2).
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // From bit 0 up: mod_value(16).
   logic [15:0] rsp_tdata;

   int error_count;
   int pending_count;
   int checked_count;
   int cycle_count = 0;
   int kind_count [4] = '{0, 0, 0, 0};
   bit send_burst = 1'b0;
   bit take_burst = 1'b0;

   modulation_matrix_sum u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   modulation_matrix_sum_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .error_count   (error_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("testbench: done, errors");
         $finish;
      end
   end

   // Fields that the request kind does not use still carry random bits.
   function automatic request_fields_type random_fields();
      request_fields_type fields;
      fields      = request_fields_type'(56'({$urandom(), $urandom()}));
      fields.fill = 1'b0;
      return fields;
   endfunction

   function automatic logic [15:0] random_value();
      case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return 16'h0000;
         3:       return 16'(signed'($urandom_range(0, 4)) - 2);
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic send_request(input req_kind_type kind, input request_fields_type fields);
      int gap;
      if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
      gap = send_burst ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= fields;
      req_tuser  <= kind;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      kind_count[kind]++;
      @(negedge clock);
   endtask

   task automatic write_slot(input logic [3:0] index, input logic [3:0] source,
                             input logic [4:0] target, input logic [15:0] depth,
                             input logic active);
      request_fields_type fields;
      fields             = random_fields();
      fields.slot_index  = index;
      fields.slot_source = source;
      fields.slot_target = target;
      fields.slot_depth  = depth;
      fields.slot_active = active;
      send_request(REQ_WRITE_SLOT, fields);
   endtask

   task automatic write_source(input logic [3:0] index, input logic [15:0] value);
      request_fields_type fields;
      fields              = random_fields();
      fields.source_index = index;
      fields.source_value = value;
      send_request(REQ_WRITE_SOURCE, fields);
   endtask

   task automatic evaluate(input logic [4:0] target);
      request_fields_type fields;
      fields             = random_fields();
      fields.eval_target = target;
      send_request(REQ_EVAL, fields);
   endtask

   // The receiver holds ready low for a random stall, or for none during a burst, before taking each response.
   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) take_burst = !take_burst;
         stall = take_burst ? 0 : $urandom_range(0, 14);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   initial begin
      int pick;
      logic [4:0] target;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: reset state, saturation both ways, rounding ties,
      // missing sources, ignored source writes, inactive slots and clear.
      evaluate(5'd0);
      write_source(4'd0, 16'h8000);
      write_slot(4'd0, 4'd0, 5'd1, 16'h8000, 1'b1);
      evaluate(5'd1);
      write_slot(4'd1, 4'd0, 5'd1, 16'h8000, 1'b1);
      evaluate(5'd1);
      write_source(4'd1, 16'h7fff);
      write_slot(4'd2, 4'd1, 5'd2, 16'h8000, 1'b1);
      write_slot(4'd3, 4'd1, 5'd2, 16'h8000, 1'b1);
      evaluate(5'd2);
      write_source(4'd2, 16'h0001);
      write_slot(4'd4, 4'd2, 5'd3, 16'h4000, 1'b1);
      evaluate(5'd3);
      write_source(4'd2, 16'hffff);
      evaluate(5'd3);
      write_slot(4'd5, 4'd12, 5'd4, 16'h7fff, 1'b1);
      write_source(4'd11, 16'h1234);
      write_source(4'd15, 16'h7fff);
      evaluate(5'd4);
      write_slot(4'd15, 4'd10, 5'd31, 16'h7fff, 1'b0);
      write_source(4'd10, 16'h7fff);
      evaluate(5'd31);
      write_slot(4'd15, 4'd10, 5'd31, 16'h7fff, 1'b1);
      evaluate(5'd31);
      send_request(REQ_CLEAR, random_fields());
      evaluate(5'd1);

      // Random part: mostly writes and evaluates that hit a few busy targets.
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         pick   = $urandom_range(0, 99);
         target = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) :
                                                 5'($urandom_range(0, 3));
         if (pick < 30) begin
            write_slot(4'($urandom_range(0, 15)),
                       ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) :
                                                     4'($urandom_range(0, 10)),
                       target, random_value(), $urandom_range(0, 5) != 0);
         end else if (pick < 58) begin
            write_source(($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) :
                                                       4'($urandom_range(0, 10)),
                         random_value());
         end else if (pick < 97) begin
            evaluate(target);
         end else begin
            send_request(REQ_CLEAR, random_fields());
         end
      end
      req_tvalid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d slot writes, %0d source writes, %0d evaluates, %0d clears",
               kind_count[REQ_WRITE_SLOT], kind_count[REQ_WRITE_SOURCE],
               kind_count[REQ_EVAL], kind_count[REQ_CLEAR]);
      $display("checked %0d responses, %0d failures", checked_count, error_count);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/mms_pkg.sv
rtl/mms_front.sv
rtl/mms_cmd_fifo.sv
rtl/mms_engine.sv
rtl/modulation_matrix_sum.sv
verif/modulation_matrix_sum_checker.sv
verif/testbench.sv
